@@ sv/assert_macros.svh @@
// Assertion macros, included by asert_target_calculation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("implication check failed");

// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

@@ sv/asert_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASERT target package
// Constants of the exponential target schedule: polynomial coefficients,
// register map and reset values.
// ----------------------------------------------------------------------------
package asert_pkg;

  localparam int DIV_STEPS = 64;

  localparam logic [63:0] POLY_C1 = 64'd195766423245049;
  localparam logic [63:0] POLY_C2 = 64'd971821376;
  localparam logic [63:0] POLY_C3 = 64'd5127;
  localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
  localparam logic [16:0] FACTOR_ONE = 17'h1_0000;

  localparam logic [2:0] REG_LIMIT0 = 3'd0;
  localparam logic [2:0] REG_LIMIT1 = 3'd1;
  localparam logic [2:0] REG_LIMIT2 = 3'd2;
  localparam logic [2:0] REG_LIMIT3 = 3'd3;
  localparam logic [2:0] REG_SPACING = 3'd4;
  localparam logic [2:0] REG_HALF_LIFE = 3'd5;

  localparam logic [63:0] LIMIT_LOW_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIMIT_TOP_RST = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] SPACING_RST = 32'd600;
  localparam logic [31:0] HALF_LIFE_RST = 32'd172800;

  typedef logic [255:0] big_t;

endpackage
`default_nettype wire

@@ sv/asert_target_calculation.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASERT target calculation
// Pipelined exponential difficulty target with clamping to the limit.
// ----------------------------------------------------------------------------
// A word is accepted at every rising edge with start high; busy stays low,
// so a new word can enter in every cycle.
// Each word gives a 224-bit reference target, a signed time difference and a
// height difference. The result stands on target_word0..3 and bad_input for
// one cycle, marked by done.
// Throughput is one word per cycle. The pipeline holds the 64-stage
// restoring divider of the exponent, one quotient bit per stage, plus
// thirteen stages for the input, drift, polynomial, multiply, shift and clamp.
// The receiver cannot stall, so no result is ever held back.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// Registers are written over the APB port at byte address 8*i; the user must
// write them only while no word is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asert_target_calculation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [55:0]        ref_word0,
  input  logic [55:0]        ref_word1,
  input  logic [55:0]        ref_word2,
  input  logic [55:0]        ref_word3,
  input  logic signed [32:0] time_diff,
  input  logic [30:0]        height_diff,
  output logic               done,
  output logic [63:0]        target_word0,
  output logic [63:0]        target_word1,
  output logic [63:0]        target_word2,
  output logic [63:0]        target_word3,
  output logic               bad_input,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import asert_pkg::*;

  logic [63:0] limit_w0, limit_w1, limit_w2, limit_w3;
  logic [31:0] spacing, half_life;
  big_t        limit;
  logic [31:0] hl;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;
  assign limit  = {limit_w3, limit_w2, limit_w1, limit_w0};
  assign hl     = (half_life == 32'd0) ? 32'd1 : half_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_w0  <= LIMIT_LOW_RST;
      limit_w1  <= LIMIT_LOW_RST;
      limit_w2  <= LIMIT_LOW_RST;
      limit_w3  <= LIMIT_TOP_RST;
      spacing   <= SPACING_RST;
      half_life <= HALF_LIFE_RST;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_LIMIT0:    limit_w0 <= pwdata;
        REG_LIMIT1:    limit_w1 <= pwdata;
        REG_LIMIT2:    limit_w2 <= pwdata;
        REG_LIMIT3:    limit_w3 <= pwdata;
        REG_SPACING:   spacing <= pwdata[31:0];
        REG_HALF_LIFE: half_life <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_LIMIT0:    prdata = limit_w0;
      REG_LIMIT1:    prdata = limit_w1;
      REG_LIMIT2:    prdata = limit_w2;
      REG_LIMIT3:    prdata = limit_w3;
      REG_SPACING:   prdata = {32'd0, spacing};
      REG_HALF_LIFE: prdata = {32'd0, half_life};
      default:       prdata = 64'd0;
    endcase
  end

  // Valid bits.
  logic in_vld, s1_vld, s2_vld;
  logic dv_vld [DIV_STEPS];
  logic s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld, s10_vld, s11_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      s4_vld  <= 1'b0;
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      in_vld  <= start && !busy;
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= dv_vld[DIV_STEPS-1];
      s4_vld  <= s3_vld;
      s5_vld  <= s4_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
      done    <= s11_vld;
    end
  end

  // Input register.
  logic [223:0]       in_ref;
  logic signed [32:0] in_td;
  logic [30:0]        in_hd;

  always_ff @(posedge clk) begin
    in_ref <= {ref_word3, ref_word2, ref_word1, ref_word0};
    in_td  <= time_diff;
    in_hd  <= height_diff;
  end

  // Stage 1: spacing times height, reference checks.
  logic [223:0]       s1_ref;
  logic signed [32:0] s1_td;
  logic [62:0]        s1_prod;
  logic               s1_refbad;
  logic [62:0]        prod_c;

  assign prod_c = spacing * in_hd;

  always_ff @(posedge clk) begin
    s1_ref    <= in_ref;
    s1_td     <= in_td;
    s1_prod   <= prod_c;
    s1_refbad <= (in_ref == 224'd0) || ({32'd0, in_ref} > limit);
  end

  // Stage 2: drift and dividend.
  logic signed [63:0] drift_c, num_c;
  logic [63:0]        mag_c;
  logic               bad2_c;
  logic [223:0]       s2_ref;
  logic [63:0]        s2_m;
  logic               s2_neg, s2_bad;

  always_comb begin
    drift_c = 64'(s1_td) - $signed({1'b0, s1_prod});
    num_c   = drift_c - $signed({32'd0, spacing});
    mag_c   = num_c[63] ? 64'(-num_c) : 64'(num_c);
    bad2_c  = s1_refbad || s1_prod[62]
           || (drift_c <= -64'sh0000_8000_0000_0000)
           || (drift_c >= 64'sh0000_8000_0000_0000);
  end

  always_ff @(posedge clk) begin
    s2_ref <= s1_ref;
    s2_m   <= {mag_c[47:0], 16'd0};
    s2_neg <= num_c[63];
    s2_bad <= bad2_c;
  end

  // Restoring divider, one quotient bit per stage.
  logic [31:0]  dv_rem [DIV_STEPS];
  logic [63:0]  dv_m   [DIV_STEPS];
  logic [63:0]  dv_q   [DIV_STEPS];
  logic [223:0] dv_ref [DIV_STEPS];
  logic         dv_neg [DIV_STEPS];
  logic         dv_bad [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0]  rem_in;
    logic [63:0]  m_in, q_in;
    logic [223:0] ref_in;
    logic         neg_in, bad_in, vld_in;
    logic [32:0]  trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = 32'd0;
      assign m_in   = s2_m;
      assign q_in   = 64'd0;
      assign ref_in = s2_ref;
      assign neg_in = s2_neg;
      assign bad_in = s2_bad;
      assign vld_in = s2_vld;
    end else begin : g_next
      assign rem_in = dv_rem[k-1];
      assign m_in   = dv_m[k-1];
      assign q_in   = dv_q[k-1];
      assign ref_in = dv_ref[k-1];
      assign neg_in = dv_neg[k-1];
      assign bad_in = dv_bad[k-1];
      assign vld_in = dv_vld[k-1];
    end

    assign trial = {rem_in, m_in[63]};
    assign ge    = trial >= {1'b0, hl};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else begin
        dv_vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k] <= ge ? 32'(trial - {1'b0, hl}) : trial[31:0];
      dv_m[k]   <= {m_in[62:0], 1'b0};
      dv_q[k]   <= {q_in[62:0], ge};
      dv_ref[k] <= ref_in;
      dv_neg[k] <= neg_in;
      dv_bad[k] <= bad_in;
    end
  end

  // Stage 3: signed exponent split into shift and fraction.
  logic [64:0]        expo_c;
  logic signed [49:0] s3_s;
  logic [15:0]        s3_frac;
  logic [223:0]       s3_ref;
  logic               s3_bad;

  assign expo_c = dv_neg[DIV_STEPS-1] ? 65'(-{1'b0, dv_q[DIV_STEPS-1]})
                                      : {1'b0, dv_q[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    s3_s    <= 50'($signed(expo_c[64:16])) - 50'sd16;
    s3_frac <= expo_c[15:0];
    s3_ref  <= dv_ref[DIV_STEPS-1];
    s3_bad  <= dv_bad[DIV_STEPS-1];
  end

  // Stage 4: fraction squared, linear term, shift decode.
  logic [49:0]  ra_c;
  logic         right_c;
  logic [31:0]  s4_f2;
  logic [63:0]  s4_t1;
  logic [15:0]  s4_frac;
  logic [223:0] s4_ref;
  logic         s4_bad, s4_left, s4_big;
  logic [7:0]   s4_amt;

  assign ra_c    = 50'(-s3_s);
  assign right_c = s3_s[49] || (s3_s == 50'sd0);

  always_ff @(posedge clk) begin
    s4_f2   <= s3_frac * s3_frac;
    s4_t1   <= 64'(POLY_C1 * {48'd0, s3_frac});
    s4_frac <= s3_frac;
    s4_ref  <= s3_ref;
    s4_bad  <= s3_bad;
    s4_left <= !right_c;
    s4_big  <= right_c ? (|ra_c[49:8]) : (|s3_s[48:8]);
    s4_amt  <= right_c ? ra_c[7:0] : s3_s[7:0];
  end

  // Stage 5: cube and square term.
  logic [47:0]  s5_f3;
  logic [63:0]  s5_t1, s5_t2;
  logic [223:0] s5_ref;
  logic         s5_bad, s5_left, s5_big;
  logic [7:0]   s5_amt;

  always_ff @(posedge clk) begin
    s5_f3   <= s4_f2 * s4_frac;
    s5_t2   <= 64'(POLY_C2 * {32'd0, s4_f2});
    s5_t1   <= s4_t1;
    s5_ref  <= s4_ref;
    s5_bad  <= s4_bad;
    s5_left <= s4_left;
    s5_big  <= s4_big;
    s5_amt  <= s4_amt;
  end

  // Stage 6: cubic term and partial sum.
  logic [63:0]  s6_t3, s6_sum;
  logic [223:0] s6_ref;
  logic         s6_bad, s6_left, s6_big;
  logic [7:0]   s6_amt;

  always_ff @(posedge clk) begin
    s6_t3   <= 64'(POLY_C3 * {16'd0, s5_f3});
    s6_sum  <= s5_t1 + s5_t2 + POLY_ROUND;
    s6_ref  <= s5_ref;
    s6_bad  <= s5_bad;
    s6_left <= s5_left;
    s6_big  <= s5_big;
    s6_amt  <= s5_amt;
  end

  // Stage 7: factor.
  logic [63:0]  poly_c;
  logic [16:0]  s7_factor;
  logic [223:0] s7_ref;
  logic         s7_bad, s7_left, s7_big;
  logic [7:0]   s7_amt;

  assign poly_c = s6_sum + s6_t3;

  always_ff @(posedge clk) begin
    s7_factor <= FACTOR_ONE + {1'b0, poly_c[63:48]};
    s7_ref    <= s6_ref;
    s7_bad    <= s6_bad;
    s7_left   <= s6_left;
    s7_big    <= s6_big;
    s7_amt    <= s6_amt;
  end

  // Stage 8: partial products of the reference times the factor.
  logic [48:0] s8_pp [7];
  logic        s8_bad, s8_left, s8_big;
  logic [7:0]  s8_amt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 7; i++) begin
      s8_pp[i] <= s7_ref[32*i +: 32] * s7_factor;
    end
    s8_bad  <= s7_bad;
    s8_left <= s7_left;
    s8_big  <= s7_big;
    s8_amt  <= s7_amt;
  end

  // Stage 9: product as the sum of the even and odd partial products.
  big_t       even_c, odd_c;
  big_t       s9_prod;
  logic       s9_bad, s9_left, s9_big;
  logic [7:0] s9_amt;

  always_comb begin
    even_c = '0;
    odd_c  = '0;
    for (int i = 0; i < 7; i += 2) begin
      even_c[64*(i/2) +: 49] = s8_pp[i];
    end
    for (int i = 1; i < 7; i += 2) begin
      odd_c[64*(i/2) + 32 +: 49] = s8_pp[i];
    end
  end

  always_ff @(posedge clk) begin
    s9_prod <= even_c + odd_c;
    s9_bad  <= s8_bad;
    s9_left <= s8_left;
    s9_big  <= s8_big;
    s9_amt  <= s8_amt;
  end

  // Stage 10: coarse shift by multiples of sixteen.
  logic [511:0] s10_w;
  logic         s10_nz, s10_bad, s10_left, s10_big;
  logic [3:0]   s10_fine;

  always_ff @(posedge clk) begin
    if (s9_left) begin
      s10_w <= {256'd0, s9_prod} << {s9_amt[7:4], 4'd0};
    end else begin
      s10_w <= {256'd0, s9_prod >> {s9_amt[7:4], 4'd0}};
    end
    s10_nz   <= |s9_prod;
    s10_bad  <= s9_bad;
    s10_left <= s9_left;
    s10_big  <= s9_big;
    s10_fine <= s9_amt[3:0];
  end

  // Stage 11: fine shift and overflow.
  logic [511:0] fine_c;
  big_t         s11_res;
  logic         s11_ovf, s11_bad;

  assign fine_c = s10_w << s10_fine;

  always_ff @(posedge clk) begin
    if (s10_left) begin
      s11_res <= fine_c[255:0];
      s11_ovf <= s10_big ? s10_nz : (|fine_c[511:256]);
    end else begin
      s11_res <= s10_big ? '0 : (s10_w[255:0] >> s10_fine);
      s11_ovf <= 1'b0;
    end
    s11_bad <= s10_bad;
  end

  // Stage 12: clamp and output register.
  big_t final_c;

  always_comb begin
    if (s11_bad || s11_ovf) begin
      final_c = limit;
    end else if (s11_res == '0) begin
      final_c = 256'd1;
    end else if (s11_res > limit) begin
      final_c = limit;
    end else begin
      final_c = s11_res;
    end
  end

  always_ff @(posedge clk) begin
    target_word0 <= final_c[63:0];
    target_word1 <= final_c[127:64];
    target_word2 <= final_c[191:128];
    target_word3 <= final_c[255:192];
    bad_input    <= s11_bad;
  end

  `ASSERT_IMPL(a_latency, clk, rst, done, $past(start && !busy, 77))
  `ASSERT_NEXT(a_bad_gives_limit, clk, rst, s11_vld && s11_bad,
    done && bad_input && ({target_word3, target_word2, target_word1, target_word0} == limit))

endmodule
`default_nettype wire
